/* hdl/itrd_pkg.sv */
package itrd_pkg;

  // fixed field widths
  localparam int VALUE_W   = 64;
  localparam int DIGIT_W   = 4;
  localparam int SYM_W     = 8;
  localparam int SIGN_W    = 2;
  localparam int RADIX_W   = 5;
  localparam int SMODE_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int BIT_CNT_W = $clog2(VALUE_W);

  // op codes
  localparam logic OP_SIGNED   = 1'b0;
  localparam logic OP_UNSIGNED = 1'b1;

  // sign codes on the first result
  localparam logic [SIGN_W-1:0] SIGN_NONE  = 2'd0;
  localparam logic [SIGN_W-1:0] SIGN_MINUS = 2'd1;
  localparam logic [SIGN_W-1:0] SIGN_PLUS  = 2'd2;
  localparam logic [SIGN_W-1:0] SIGN_SPACE = 2'd3;

  // sign mode register codes
  localparam logic [SMODE_W-1:0] SMODE_NONE  = 2'd0;
  localparam logic [SMODE_W-1:0] SMODE_SPACE = 2'd1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HIGH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGN_MODE  = 2'd3;

  // configuration reset values
  localparam logic [RADIX_W-1:0] RADIX_RST      = 5'd10;
  localparam logic [VALUE_W-1:0] ALPHA_LOW_RST  = 64'h3736353433323130;
  localparam logic [VALUE_W-1:0] ALPHA_HIGH_RST = 64'h4645444342413938;
  localparam logic [SMODE_W-1:0] SMODE_RST      = SMODE_NONE;

  // configuration as seen by the front and back parts
  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    logic [VALUE_W-1:0] alpha_low;
    logic [VALUE_W-1:0] alpha_high;
    logic [SMODE_W-1:0] sign_mode;
  } itrd_cfg_t;

  // one classified number waiting for conversion
  typedef struct packed {
    logic [VALUE_W-1:0] mag;
    logic [SIGN_W-1:0]  sign;
  } itrd_job_t;

  // alphabet lookup of one digit
  function automatic logic [SYM_W-1:0] symbol_of(input logic [VALUE_W-1:0] lo,
                                                 input logic [VALUE_W-1:0] hi,
                                                 input logic [DIGIT_W-1:0] d);
    logic [VALUE_W-1:0] word;
    word = d[DIGIT_W-1] ? hi : lo;
    return word[{d[DIGIT_W-2:0], 3'b000} +: SYM_W];
  endfunction

endpackage

/* hdl/itrd_ram.sv */
module itrd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/itrd_fifo.sv */
module itrd_fifo #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  itrd_pkg::itrd_job_t push_job,
  output logic               full,
  input  logic               pop,
  output itrd_pkg::itrd_job_t pop_job,
  output logic               empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  itrd_pkg::itrd_job_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign pop_job = slots[rd_ptr];

  // slot storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/itrd_front.sv */
module itrd_front (
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [itrd_pkg::VALUE_W-1:0]          s_tdata,
  input  logic                                  s_tuser,
  input  logic [itrd_pkg::SMODE_W-1:0]          sign_mode,
  input  logic                                  q_full,
  output logic                                  push,
  output itrd_pkg::itrd_job_t                   push_job
);

  logic negative;

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;
  assign negative = (s_tuser == itrd_pkg::OP_SIGNED) && s_tdata[itrd_pkg::VALUE_W-1];

  // sign decision and magnitude
  always_comb begin
    if (negative) begin
      push_job.mag  = ~s_tdata + 1'b1;
      push_job.sign = itrd_pkg::SIGN_MINUS;
    end else begin
      push_job.mag = s_tdata;
      if (s_tuser == itrd_pkg::OP_UNSIGNED) begin
        push_job.sign = itrd_pkg::SIGN_NONE;
      end else if (sign_mode[1]) begin
        push_job.sign = itrd_pkg::SIGN_PLUS;
      end else if (sign_mode == itrd_pkg::SMODE_SPACE) begin
        push_job.sign = itrd_pkg::SIGN_SPACE;
      end else begin
        push_job.sign = itrd_pkg::SIGN_NONE;
      end
    end
  end

endmodule

/* hdl/itrd_back.sv */
module itrd_back #(
  parameter int MAX_RADIX  = 16,
  parameter int MAX_DIGITS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  itrd_pkg::itrd_cfg_t             cfg,
  input  logic                            q_empty,
  input  itrd_pkg::itrd_job_t             q_job,
  output logic                            pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [itrd_pkg::SYM_W-1:0]      m_tdata,
  output logic [itrd_pkg::SIGN_W-1:0]     m_tuser,
  output logic                            m_tlast
);

  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int VW    = itrd_pkg::VALUE_W;
  localparam int DW    = itrd_pkg::DIGIT_W;
  localparam int RW    = itrd_pkg::RADIX_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_LOAD
  } state_t;

  state_t                       state;
  logic [VW-1:0]                quot;
  logic [DW-1:0]                rem;
  logic [itrd_pkg::BIT_CNT_W-1:0] bit_cnt;
  logic [CNT_W-1:0]             count;
  logic [IDX_W-1:0]             rd_addr;
  logic [itrd_pkg::SIGN_W-1:0]  sign;
  logic                         first;

  logic [RW-1:0]   radix_eff;
  logic [DW:0]     trial;
  logic            take;
  logic [DW:0]     diff;
  logic [DW-1:0]   rem_next;
  logic [VW-1:0]   quot_next;
  logic            bit_last;
  logic            digit_done;
  logic            div_end;
  logic            out_free;
  logic [DW-1:0]   rd_digit;

  // radix clamped into the supported range
  always_comb begin
    radix_eff = cfg.radix;
    if (radix_eff < RW'(2)) begin
      radix_eff = RW'(2);
    end
    if (radix_eff > RW'(MAX_RADIX)) begin
      radix_eff = RW'(MAX_RADIX);
    end
  end

  // one restoring division step per cycle
  assign trial     = {rem, quot[VW-1]};
  assign take      = (trial >= radix_eff);
  assign diff      = trial - radix_eff;
  assign rem_next  = take ? diff[DW-1:0] : trial[DW-1:0];
  assign quot_next = {quot[VW-2:0], take};
  assign bit_last  = (bit_cnt == itrd_pkg::BIT_CNT_W'(VW - 1));

  // digit finished, and whether the division pass ends with it
  assign digit_done = (state == ST_DIV) && bit_last;
  assign div_end    = (quot_next == '0) || (count + 1'b1 == CNT_W'(MAX_DIGITS));

  assign pop      = (state == ST_IDLE) && !q_empty;
  assign out_free = !m_tvalid || m_tready;

  // digit store, least significant digit at address 0
  itrd_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_DIGITS)
  ) u_digits (
    .clk     (clk),
    .wr_en   (digit_done),
    .wr_addr (count[IDX_W-1:0]),
    .wr_data (rem_next),
    .rd_addr (rd_addr),
    .rd_data (rd_digit)
  );

  // sequencer: division pass, then emission pass most significant first
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      quot     <= '0;
      rem      <= '0;
      bit_cnt  <= '0;
      count    <= '0;
      rd_addr  <= '0;
      sign     <= itrd_pkg::SIGN_NONE;
      first    <= 1'b0;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
      m_tuser  <= itrd_pkg::SIGN_NONE;
      m_tlast  <= 1'b0;
    end else begin
      // output taken and no new symbol loaded this cycle
      if (m_tvalid && m_tready && (state != ST_LOAD)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            quot    <= q_job.mag;
            sign    <= q_job.sign;
            rem     <= '0;
            bit_cnt <= '0;
            count   <= '0;
            first   <= 1'b1;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          quot    <= quot_next;
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_last) begin
            rem   <= '0;
            count <= count + 1'b1;
            if (div_end) begin
              rd_addr <= count[IDX_W-1:0];
              state   <= ST_RD;
            end
          end else begin
            rem <= rem_next;
          end
        end
        ST_RD: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= itrd_pkg::symbol_of(cfg.alpha_low, cfg.alpha_high, rd_digit);
            m_tuser  <= first ? sign : itrd_pkg::SIGN_NONE;
            m_tlast  <= (rd_addr == '0);
            first    <= 1'b0;
            if (rd_addr == '0) begin
              state <= ST_IDLE;
            end else begin
              rd_addr <= rd_addr - 1'b1;
              state   <= ST_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/integer_to_radix_digits_top.sv */
// channel | direction | handshake          | payload
// s       | in        | s_tvalid/s_tready  | s_tdata = value, s_tuser = op
// m       | out       | m_tvalid/m_tready  | m_tdata = symbol, m_tuser = sign_code,
//         |           |                    | m_tlast = last
// cfg     | in        | cfg_valid/cfg_ready| cfg_index = register, cfg_data = value
//
// each digit is formed bit by bit on the shared bit-serial divider, and each symbol
// then passes through the registered digit store read (ST_RD, then ST_LOAD); an item
// has up to 64 digits, and the next item starts only once its last symbol is loaded.
// a two-entry queue lets the input side accept items while the divider works.
// rst is synchronous; no clearing pass is needed. either side may stall freely.
module integer_to_radix_digits_top #(
  parameter int MAX_RADIX  = 16,
  parameter int MAX_DIGITS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [itrd_pkg::VALUE_W-1:0]      s_tdata,   // [63:0] value
  input  logic                              s_tuser,   // [0] op
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [itrd_pkg::SYM_W-1:0]        m_tdata,   // [7:0] symbol
  output logic [itrd_pkg::SIGN_W-1:0]       m_tuser,   // [1:0] sign_code
  output logic                              m_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [itrd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [itrd_pkg::VALUE_W-1:0]      cfg_data
);

  itrd_pkg::itrd_cfg_t cfg;
  itrd_pkg::itrd_job_t push_job;
  itrd_pkg::itrd_job_t pop_job;
  logic                push;
  logic                pop;
  logic                q_full;
  logic                q_empty;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radix      <= itrd_pkg::RADIX_RST;
      cfg.alpha_low  <= itrd_pkg::ALPHA_LOW_RST;
      cfg.alpha_high <= itrd_pkg::ALPHA_HIGH_RST;
      cfg.sign_mode  <= itrd_pkg::SMODE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        itrd_pkg::CFG_RADIX:      cfg.radix      <= cfg_data[itrd_pkg::RADIX_W-1:0];
        itrd_pkg::CFG_ALPHA_LOW:  cfg.alpha_low  <= cfg_data;
        itrd_pkg::CFG_ALPHA_HIGH: cfg.alpha_high <= cfg_data;
        itrd_pkg::CFG_SIGN_MODE:  cfg.sign_mode  <= cfg_data[itrd_pkg::SMODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // classify incoming items
  itrd_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .sign_mode (cfg.sign_mode),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  // queue between classification and conversion
  itrd_fifo #(
    .DEPTH (2)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  // division and emission
  itrd_back #(
    .MAX_RADIX  (MAX_RADIX),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_job    (pop_job),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
